// ===== hw/rtl/cau_pkg.sv =====
package cau_pkg;

  localparam int DefWordBits = 32;
  localparam int DefFracBits = 16;
  localparam int FieldBits   = 32;

  typedef enum logic [2:0] {
    OpAdd  = 3'd0,
    OpSub  = 3'd1,
    OpMul  = 3'd2,
    OpDiv  = 3'd3,
    OpConj = 3'd4,
    OpMag  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StOverflow = 2'd1,
    StDivZero  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]                  operation;
    logic signed [FieldBits-1:0] a_real;
    logic signed [FieldBits-1:0] a_imag;
    logic signed [FieldBits-1:0] b_real;
    logic signed [FieldBits-1:0] b_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [FieldBits-1:0] res_real;
    logic signed [FieldBits-1:0] res_imag;
    logic [1:0]                  status;
  } cau_out_t;

endpackage

// ===== hw/rtl/complex_arithmetic_unit_core.sv =====
// Complex ALU on signed fixed-point operands (Q16.16 at the default widths).
// Input channel: drive in_i and raise start; the beat is taken at the rising
// edge where start is high and busy is low. busy stays low, so a new beat
// can enter at every clock cycle.
// Operations: add, subtract, multiply, divide, conjugate of a, magnitude of a.
// Result channel: res_o is valid for exactly one cycle while done_o is high.
// The receiver cannot stall; every result is shown once and then replaced.
// done_o follows the accepting edge through the same pipeline depth for
// every operation. Throughput: one beat per cycle.
// The depth is set by the restoring divider: one setup stage, then one
// quotient bit per stage (WORD_BITS+1 stages), with the integer square root
// sharing those stages at one root bit per stage. Four stages in front do
// operand capture, products, sums and magnitudes, one stage behind does
// saturation.
// Reset clears only the valid bits of the pipeline; results in flight are
// dropped and done_o stays low until a new beat has gone through.
module complex_arithmetic_unit_core #(
  parameter int WORD_BITS = cau_pkg::DefWordBits,
  parameter int FRAC_BITS = cau_pkg::DefFracBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cau_pkg::cau_in_t  in_i,
  output logic              done_o,
  output cau_pkg::cau_out_t res_o
);
  import cau_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int SW  = 2 * W + 1;
  localparam int XW  = 2 * W + ((F > W + 1) ? F : W + 1) + 1;
  localparam int QW  = W + 1;
  localparam int Lat = W + 7;

  localparam logic [W-1:0] PosMaxW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NegMinW = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [2:0]          op;
    logic signed [W-1:0] ar;
    logic signed [W-1:0] ai;
    logic signed [W-1:0] br;
    logic signed [W-1:0] bi;
  } s0_t;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
    logic signed [PW-1:0] q_ar;
    logic signed [PW-1:0] q_ai;
    logic signed [PW-1:0] q_br;
    logic signed [PW-1:0] q_bi;
    logic [W-1:0]         re;
    logic [W-1:0]         im;
    logic                 ov;
  } s1_t;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [SW-1:0] m_re;
    logic signed [SW-1:0] m_im;
    logic signed [SW-1:0] n_re;
    logic signed [SW-1:0] n_im;
    logic [PW-1:0]        d;
    logic [PW-1:0]        n;
    logic [W-1:0]         re;
    logic [W-1:0]         im;
    logic                 ov;
  } s2_t;

  typedef struct packed {
    logic [2:0]    op;
    logic [W-1:0]  re;
    logic [W-1:0]  im;
    logic          ov;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic [PW-1:0] mag_re;
    logic [PW-1:0] mag_im;
    logic [PW-1:0] d;
    logic [PW-1:0] n;
  } s3_t;

  typedef struct packed {
    logic [2:0]    op;
    logic [W-1:0]  re;
    logic [W-1:0]  im;
    logic          ov;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic          ovf_re;
    logic          ovf_im;
    logic [XW-1:0] rem_re;
    logic [XW-1:0] rem_im;
    logic [QW-1:0] q_re;
    logic [QW-1:0] q_im;
    logic [PW-1:0] d;
    logic [PW-1:0] srem;
    logic [W-1:0]  root;
  } step_t;

  // signed value out of the word range clamps to the nearest bound
  function automatic logic sat_ovf(input logic signed [SW-1:0] v);
    logic [SW-W:0] top;
    top = v[SW-1:W-1];
    return !(&top) && (|top);
  endfunction

  function automatic logic [W-1:0] sat_val(input logic signed [SW-1:0] v);
    logic [W-1:0] r;
    if (sat_ovf(v)) begin
      r = v[SW-1] ? NegMinW : PosMaxW;
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  // quotient magnitude with sign, clamped; msb of the result is overflow
  function automatic logic [W:0] div_sat(input logic neg, input logic big,
                                         input logic [QW-1:0] q);
    logic         ov;
    logic [W-1:0] val;
    logic [QW-1:0] nq;
    nq = -q;
    if (neg) begin
      ov  = big | q[W] | (q[W-1] & (|q[W-2:0]));
      val = ov ? NegMinW : nq[W-1:0];
    end else begin
      ov  = big | q[W] | q[W-1];
      val = ov ? PosMaxW : q[W-1:0];
    end
    return {ov, val};
  endfunction

  logic           accept;
  logic [Lat-1:0] vld_d, vld_q;

  s0_t   s0_d, s0_q;
  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;
  s3_t   s3_d, s3_q;
  step_t step_d [W+2];
  step_t step_q [W+2];
  cau_out_t out_d, out_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign vld_d  = {vld_q[Lat-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // operand capture, low word bits of each field kept, upper field bits ignored
  always_comb begin
    s0_d.op = in_i.operation;
    s0_d.ar = in_i.a_real[W-1:0];
    s0_d.ai = in_i.a_imag[W-1:0];
    s0_d.br = in_i.b_real[W-1:0];
    s0_d.bi = in_i.b_imag[W-1:0];
  end

  // products and the short add, subtract and conjugate results
  always_comb begin
    logic signed [W:0] sum_re, sum_im, dif_re, dif_im, neg_ai;
    sum_re = (W+1)'(s0_q.ar) + (W+1)'(s0_q.br);
    sum_im = (W+1)'(s0_q.ai) + (W+1)'(s0_q.bi);
    dif_re = (W+1)'(s0_q.ar) - (W+1)'(s0_q.br);
    dif_im = (W+1)'(s0_q.ai) - (W+1)'(s0_q.bi);
    neg_ai = -(W+1)'(s0_q.ai);
    s1_d.op   = s0_q.op;
    s1_d.p_rr = PW'(s0_q.ar) * PW'(s0_q.br);
    s1_d.p_ii = PW'(s0_q.ai) * PW'(s0_q.bi);
    s1_d.p_ri = PW'(s0_q.ar) * PW'(s0_q.bi);
    s1_d.p_ir = PW'(s0_q.ai) * PW'(s0_q.br);
    s1_d.q_ar = PW'(s0_q.ar) * PW'(s0_q.ar);
    s1_d.q_ai = PW'(s0_q.ai) * PW'(s0_q.ai);
    s1_d.q_br = PW'(s0_q.br) * PW'(s0_q.br);
    s1_d.q_bi = PW'(s0_q.bi) * PW'(s0_q.bi);
    unique case (op_e'(s0_q.op))
      OpAdd: begin
        s1_d.re = sat_val(SW'(sum_re));
        s1_d.im = sat_val(SW'(sum_im));
        s1_d.ov = sat_ovf(SW'(sum_re)) | sat_ovf(SW'(sum_im));
      end
      OpSub: begin
        s1_d.re = sat_val(SW'(dif_re));
        s1_d.im = sat_val(SW'(dif_im));
        s1_d.ov = sat_ovf(SW'(dif_re)) | sat_ovf(SW'(dif_im));
      end
      OpConj: begin
        s1_d.re = s0_q.ar;
        s1_d.im = sat_val(SW'(neg_ai));
        s1_d.ov = sat_ovf(SW'(neg_ai));
      end
      default: begin
        s1_d.re = '0;
        s1_d.im = '0;
        s1_d.ov = 1'b0;
      end
    endcase
  end

  // exact sums of products
  always_comb begin
    logic signed [SW-1:0] d_s, n_s;
    d_s = SW'(s1_q.q_br) + SW'(s1_q.q_bi);
    n_s = SW'(s1_q.q_ar) + SW'(s1_q.q_ai);
    s2_d.op   = s1_q.op;
    s2_d.m_re = SW'(s1_q.p_rr) - SW'(s1_q.p_ii);
    s2_d.m_im = SW'(s1_q.p_ri) + SW'(s1_q.p_ir);
    s2_d.n_re = SW'(s1_q.p_rr) + SW'(s1_q.p_ii);
    s2_d.n_im = SW'(s1_q.p_ir) - SW'(s1_q.p_ri);
    s2_d.d    = d_s[PW-1:0];
    s2_d.n    = n_s[PW-1:0];
    s2_d.re   = s1_q.re;
    s2_d.im   = s1_q.im;
    s2_d.ov   = s1_q.ov;
  end

  // multiply result, dividend magnitudes and zero divisor
  always_comb begin
    logic signed [SW-1:0] sh_re, sh_im, a_re, a_im;
    sh_re = s2_q.m_re >>> F;
    sh_im = s2_q.m_im >>> F;
    a_re  = s2_q.n_re[SW-1] ? -s2_q.n_re : s2_q.n_re;
    a_im  = s2_q.n_im[SW-1] ? -s2_q.n_im : s2_q.n_im;
    s3_d.op = s2_q.op;
    if (op_e'(s2_q.op) == OpMul) begin
      s3_d.re = sat_val(sh_re);
      s3_d.im = sat_val(sh_im);
      s3_d.ov = sat_ovf(sh_re) | sat_ovf(sh_im);
    end else begin
      s3_d.re = s2_q.re;
      s3_d.im = s2_q.im;
      s3_d.ov = s2_q.ov;
    end
    s3_d.dz     = (s2_q.d == '0);
    s3_d.neg_re = s2_q.n_re[SW-1];
    s3_d.neg_im = s2_q.n_im[SW-1];
    s3_d.mag_re = a_re[PW-1:0];
    s3_d.mag_im = a_im[PW-1:0];
    s3_d.d      = s2_q.d;
    s3_d.n      = s2_q.n;
  end

  // divider setup: quotients of W+2 bits or more can only saturate
  always_comb begin
    logic [XW-1:0] x_re, x_im, d_top;
    x_re  = XW'(s3_q.mag_re) << F;
    x_im  = XW'(s3_q.mag_im) << F;
    d_top = XW'(s3_q.d) << (W + 1);
    step_d[0].op     = s3_q.op;
    step_d[0].re     = s3_q.re;
    step_d[0].im     = s3_q.im;
    step_d[0].ov     = s3_q.ov;
    step_d[0].dz     = s3_q.dz;
    step_d[0].neg_re = s3_q.neg_re;
    step_d[0].neg_im = s3_q.neg_im;
    step_d[0].ovf_re = (x_re >= d_top);
    step_d[0].ovf_im = (x_im >= d_top);
    step_d[0].rem_re = x_re;
    step_d[0].rem_im = x_im;
    step_d[0].q_re   = '0;
    step_d[0].q_im   = '0;
    step_d[0].d      = s3_q.d;
    step_d[0].srem   = s3_q.n;
    step_d[0].root   = '0;
  end

  // one quotient bit per stage, and one root bit in every stage but the last
  for (genvar k = 0; k <= W; k++) begin : g_step
    localparam int QBit = W - k;
    always_comb begin
      logic [XW-1:0] dsh;
      logic          b_re, b_im;
      logic [SW-1:0] trial;
      logic          b_rt;
      step_d[k+1] = step_q[k];
      dsh  = XW'(step_q[k].d) << QBit;
      b_re = (step_q[k].rem_re >= dsh);
      b_im = (step_q[k].rem_im >= dsh);
      if (b_re) begin
        step_d[k+1].rem_re = step_q[k].rem_re - dsh;
      end
      if (b_im) begin
        step_d[k+1].rem_im = step_q[k].rem_im - dsh;
      end
      step_d[k+1].q_re = {step_q[k].q_re[QW-2:0], b_re};
      step_d[k+1].q_im = {step_q[k].q_im[QW-2:0], b_im};
      trial = '0;
      b_rt  = 1'b0;
      if (k < W) begin
        // root bits found so far, next bit tried as (4*r+1) << 2i
        trial = ((SW'(step_q[k].root) << 2) | SW'(1)) << (2 * (W - 1 - k));
        b_rt  = (SW'(step_q[k].srem) >= trial);
        if (b_rt) begin
          step_d[k+1].srem = step_q[k].srem - trial[PW-1:0];
        end
        step_d[k+1].root = {step_q[k].root[W-2:0], b_rt};
      end
    end
  end

  // final saturation and status
  always_comb begin
    step_t        t;
    logic [W:0]   dr, di;
    logic [W-1:0] re, im;
    logic         ov, dz;
    t  = step_q[W+1];
    dr = div_sat(t.neg_re, t.ovf_re, t.q_re);
    di = div_sat(t.neg_im, t.ovf_im, t.q_im);
    re = '0;
    im = '0;
    ov = 1'b0;
    dz = 1'b0;
    unique case (op_e'(t.op))
      OpAdd, OpSub, OpMul, OpConj: begin
        re = t.re;
        im = t.im;
        ov = t.ov;
      end
      OpDiv: begin
        if (t.dz) begin
          re = PosMaxW;
          im = PosMaxW;
          dz = 1'b1;
        end else begin
          re = dr[W-1:0];
          im = di[W-1:0];
          ov = dr[W] | di[W];
        end
      end
      OpMag: begin
        ov = t.root[W-1];
        re = ov ? PosMaxW : t.root;
      end
      default: begin
        re = '0;
      end
    endcase
    out_d.res_real = FieldBits'($signed(re));
    out_d.res_imag = FieldBits'($signed(im));
    if (dz) begin
      out_d.status = StDivZero;
    end else if (ov) begin
      out_d.status = StOverflow;
    end else begin
      out_d.status = StOk;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q  <= s0_d;
    s1_q  <= s1_d;
    s2_q  <= s2_d;
    s3_q  <= s3_d;
    out_q <= out_d;
  end

  for (genvar j = 0; j <= W + 1; j++) begin : g_step_reg
    always_ff @(posedge clk_i) begin
      step_q[j] <= step_d[j];
    end
  end

  assign done_o = vld_q[Lat-1];
  assign res_o  = out_q;

`ifndef NO_ASSERTIONS
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(Lat) done_o)
    else $error("accepted beat did not come out after the pipeline depth");

  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Lat))
    else $error("result beat without a matching accepted beat");

  a_div_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == StDivZero) |->
      (res_o.res_real == res_o.res_imag) && !res_o.res_real[FieldBits-1])
    else $error("zero divisor result is not saturated positive");
`endif

endmodule
